// File: design/crc_checked_sample_buffer_commands_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample buffer command block
// Each macro expects clk and arst_n in scope of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_SAMPLE_BUFFER_COMMANDS_TOP_ASSERT_SVH
`define CRC_CHECKED_SAMPLE_BUFFER_COMMANDS_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge out of reset
`define CCSBC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccsbc same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset
`define CCSBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccsbc next-cycle check failed");

`else

`define CCSBC_ASSERT_NOW(lbl, ante, cons)
`define CCSBC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/ccsbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsbc_pkg
// Shared types, codes and the CRC-8 byte update for the sample buffer block.
// ----------------------------------------------------------------------------
package ccsbc_pkg;

	// Store geometry
	localparam int STORE_DEPTH = 512;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IDX_W       = 17;
	localparam logic [IDX_W-1:0]  STORE_LIMIT = IDX_W'(STORE_DEPTH);
	localparam logic [ADDR_W-1:0] ADDR_LAST   = ADDR_W'(STORE_DEPTH - 1);

	// CRC-8, reflected, LSB first
	localparam logic [7:0] CRC_POLY  = 8'h8c;
	localparam int         CRC_BYTES = 7;
	localparam int         CRC_DATA_W = CRC_BYTES * 8;

	// Command codes
	localparam logic [7:0] CMD_READ      = 8'd2;
	localparam logic [7:0] CMD_WRITE     = 8'd3;
	localparam logic [7:0] CMD_ADC       = 8'd4;
	localparam logic [7:0] CMD_CLEAR     = 8'd8;
	localparam logic [7:0] CMD_FILL      = 8'd9;
	localparam logic [7:0] CMD_CHECK_ON  = 8'd10;
	localparam logic [7:0] CMD_CHECK_OFF = 8'd11;

	// Status and filler codes
	localparam logic [7:0] ST_DONE      = 8'd0;
	localparam logic [7:0] ST_INDEX_ERR = 8'd66;
	localparam logic [7:0] FILLER       = 8'd255;

	typedef struct packed {
		logic [7:0] command;
		logic [7:0] index_high;
		logic [7:0] index_low;
		logic [7:0] write_value;
		logic [7:0] arg_four;
		logic [7:0] arg_five;
		logic [7:0] arg_six;
		logic [7:0] check_byte;
		logic [7:0] adc_value;
	} cmd_pkt_t;

	typedef struct packed {
		logic [7:0] reply_status;
		logic [7:0] reply_command;
		logic [7:0] reply_byte_two;
		logic [7:0] reply_byte_three;
		logic [7:0] reply_byte_four;
		logic [7:0] reply_byte_five;
		logic [7:0] reply_byte_six;
		logic [7:0] reply_check;
	} reply_pkt_t;

	// Control into the CRC engine: byte 0 sits in the low bits of data
	typedef struct packed {
		logic                  start;
		logic [CRC_DATA_W-1:0] data;
	} crc_ctrl_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] crc;
	} crc_stat_t;

	// Fold one byte into the running CRC, LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ data[k];
			r  = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

// File: design/crc_checked_sample_buffer_commands_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_sample_buffer_commands_top
// Command packet processor over a 512-byte sample store with CRC-8 checking.
// ----------------------------------------------------------------------------
// Takes one 9-byte command packet per transaction and answers with at most one
// 8-byte reply. One packet is in work at a time. A byte-serial CRC engine
// checks the packet when check mode is on at acceptance, and computes the
// reply CRC when check mode is on after the command. Execution passes through
// the execute state, a read state for an in-range read and the reply state,
// then hands the reply to the output register. Clear and fill walk the store
// through its single write port, one entry per cycle, over all STORE_DEPTH
// (512) entries. After reset the block runs a clearing pass over the store
// and stalls the request channel until it is done. A packet that fails the
// check is dropped without a reply. The reply register lets the next packet
// be taken while a reply still waits downstream.
`include "crc_checked_sample_buffer_commands_top_assert.svh"

module crc_checked_sample_buffer_commands_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  ccsbc_pkg::cmd_pkt_t    req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output ccsbc_pkg::reply_pkt_t  rsp
);
	import ccsbc_pkg::*;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_CHECK,
		S_EXEC,
		S_READ,
		S_REPLY,
		S_RCRC,
		S_OUT
	} state_t;

	state_t              state_q;
	cmd_pkt_t            pkt_q;
	reply_pkt_t          rep_q;
	reply_pkt_t          rep_build;
	reply_pkt_t          rsp_q;
	logic                rsp_valid_q;
	logic                check_en_q;
	logic [7:0]          last_check_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [7:0]          fill_q;
	logic                sweep_cmd_q;
	logic [7:0]          rdata_q;

	logic [7:0]          store_mem [STORE_DEPTH];

	logic                accept;
	logic                rsp_free;
	logic                rsp_load;
	logic [15:0]         idx;
	logic                in_range;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [7:0]          mem_wdata;
	logic                mem_re;
	crc_ctrl_t           crc_ctrl;
	crc_stat_t           crc_stat;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == S_OUT) && rsp_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Decode the store index
	assign idx      = {pkt_q.index_high, pkt_q.index_low};
	assign in_range = ({1'b0, idx} < STORE_LIMIT);

	// Build the reply bytes for the command in hand
	always_comb begin
		rep_build = '{default: FILLER};
		case (pkt_q.command)
			CMD_READ: begin
				rep_build.reply_status     = in_range ? ST_DONE : ST_INDEX_ERR;
				rep_build.reply_command    = pkt_q.command;
				rep_build.reply_byte_two   = pkt_q.index_high;
				rep_build.reply_byte_three = pkt_q.index_low;
			end
			CMD_WRITE: begin
				rep_build.reply_status     = in_range ? ST_DONE : ST_INDEX_ERR;
				rep_build.reply_command    = pkt_q.command;
				rep_build.reply_byte_two   = pkt_q.index_high;
				rep_build.reply_byte_three = pkt_q.index_low;
				rep_build.reply_byte_four  = pkt_q.write_value;
			end
			CMD_ADC: begin
				rep_build.reply_status   = ST_DONE;
				rep_build.reply_command  = pkt_q.command;
				rep_build.reply_byte_two = pkt_q.adc_value;
			end
			CMD_FILL: begin
				rep_build.reply_status   = ST_DONE;
				rep_build.reply_command  = pkt_q.command;
				rep_build.reply_byte_two = pkt_q.index_high;
			end
			CMD_CLEAR, CMD_CHECK_ON, CMD_CHECK_OFF: begin
				rep_build.reply_status  = ST_DONE;
				rep_build.reply_command = pkt_q.command;
			end
			default: begin
			end
		endcase
	end

	// Drive store port controls from the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = fill_q;
		mem_re    = 1'b0;
		if (state_q == S_SWEEP) begin
			mem_we = 1'b1;
		end else if (state_q == S_EXEC && in_range) begin
			if (pkt_q.command == CMD_WRITE) begin
				mem_we    = 1'b1;
				mem_waddr = idx[ADDR_W-1:0];
				mem_wdata = pkt_q.write_value;
			end else if (pkt_q.command == CMD_READ) begin
				mem_re = 1'b1;
			end
		end
	end

	// Start the CRC engine on the packet or on the reply
	always_comb begin
		crc_ctrl.start = 1'b0;
		crc_ctrl.data  = {req.arg_six, req.arg_five, req.arg_four, req.write_value,
			req.index_low, req.index_high, req.command};
		if (state_q == S_IDLE) begin
			crc_ctrl.start = accept && check_en_q;
		end else if (state_q == S_REPLY) begin
			crc_ctrl.start = check_en_q;
			crc_ctrl.data  = {rep_q.reply_byte_six, rep_q.reply_byte_five,
				rep_q.reply_byte_four, rep_q.reply_byte_three, rep_q.reply_byte_two,
				rep_q.reply_command, rep_q.reply_status};
		end
	end

	ccsbc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.stat   (crc_stat)
	);

	// Sample store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= store_mem[idx[ADDR_W-1:0]];
		end
	end

	// Sequence each transaction through check, execute and reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			addr_q       <= '0;
			fill_q       <= '0;
			sweep_cmd_q  <= 1'b0;
			check_en_q   <= 1'b1;
			last_check_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_SWEEP: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_LAST) begin
						addr_q  <= '0;
						state_q <= sweep_cmd_q ? S_REPLY : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						pkt_q   <= req;
						state_q <= check_en_q ? S_CHECK : S_EXEC;
					end
				end
				S_CHECK: begin
					if (!crc_stat.busy) begin
						state_q <= (crc_stat.crc == pkt_q.check_byte) ? S_EXEC : S_IDLE;
					end
				end
				S_EXEC: begin
					rep_q   <= rep_build;
					state_q <= S_REPLY;
					case (pkt_q.command)
						CMD_READ: begin
							if (in_range) begin
								state_q <= S_READ;
							end
						end
						CMD_CLEAR: begin
							fill_q      <= '0;
							addr_q      <= '0;
							sweep_cmd_q <= 1'b1;
							state_q     <= S_SWEEP;
						end
						CMD_FILL: begin
							fill_q      <= pkt_q.index_high;
							addr_q      <= '0;
							sweep_cmd_q <= 1'b1;
							state_q     <= S_SWEEP;
						end
						CMD_CHECK_ON: begin
							check_en_q <= 1'b1;
						end
						CMD_CHECK_OFF: begin
							check_en_q <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				S_READ: begin
					rep_q.reply_byte_four <= rdata_q;
					state_q               <= S_REPLY;
				end
				S_REPLY: begin
					state_q <= check_en_q ? S_RCRC : S_OUT;
				end
				S_RCRC: begin
					if (!crc_stat.busy) begin
						last_check_q <= crc_stat.crc;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp_free) begin
						rsp_q   <= {rep_q[63:8], last_check_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The CRC engine is never restarted mid-pass
	`CCSBC_ASSERT_NOW(a_crc_start_idle, crc_ctrl.start, !crc_stat.busy)

	// The store port never reads and writes in the same cycle
	`CCSBC_ASSERT_NOW(a_mem_single_access, mem_we, !mem_re)

	// With check mode on, the delivered check byte is the engine's result
	`CCSBC_ASSERT_NEXT(a_reply_crc, rsp_load && check_en_q, rsp_q.reply_check == crc_stat.crc)

endmodule

// File: design/ccsbc_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsbc_crc
// Byte-serial CRC-8 engine: one byte per cycle over seven bytes.
// ----------------------------------------------------------------------------
module ccsbc_crc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccsbc_pkg::crc_ctrl_t  ctrl,
	output ccsbc_pkg::crc_stat_t  stat
);
	import ccsbc_pkg::*;

	localparam int CNT_W = $clog2(CRC_BYTES + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic [7:0]            crc_q;
	logic [CRC_DATA_W-1:0] data_q;
	logic                  busy;

	assign busy = (cnt_q != '0);

	// Count bytes and fold them into the CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= CNT_W'(CRC_BYTES);
			crc_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			crc_q <= crc8_byte(crc_q, data_q[7:0]);
		end
	end

	// Shift the operand down one byte per step
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			data_q <= ctrl.data;
		end else if (busy) begin
			data_q <= data_q >> 8;
		end
	end

	assign stat.busy = busy;
	assign stat.crc  = crc_q;

endmodule

// File: bench/crc_checked_sample_buffer_commands_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_sample_buffer_commands_top_test
// Self-checking bench for the CRC-checked sample buffer command block.
// ----------------------------------------------------------------------------
// Walks a short table of directed packets (store bounds, index errors, every
// command, unknown codes, dropped packets, check mode switching), then sends
// random packets, mostly well formed with a correct CRC and some with a broken
// one. A shadow copy of the store, the check mode and the last reply CRC
// predicts each reply that the table does not give. Both channels idle and
// stall at random, with one stretch running at full rate.
// ----------------------------------------------------------------------------
module crc_checked_sample_buffer_commands_top_test;
	import ccsbc_pkg::*;

	localparam int RANDOM_REPLIES = 600;
	localparam int IDLE_PCT       = 37;
	localparam int DRAIN_CYCLES   = 600;

	typedef enum {CRC_GOOD, CRC_BAD, CRC_RAW} crc_fix_t;

	typedef struct {
		cmd_pkt_t   pkt;
		crc_fix_t   fix;
		bit         typed;
		reply_pkt_t reply;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	cmd_pkt_t   req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	reply_pkt_t rsp;

	// Shadow state of the block
	logic [7:0] shadow_store [STORE_DEPTH];
	bit         shadow_check_on = 1'b1;
	logic [7:0] shadow_last_check = 8'h00;

	reply_pkt_t pending_replies [$];
	stim_row_t  directed_rows [$];
	string      reply_field_name [8] = '{"reply_status", "reply_command", "reply_byte_two",
		"reply_byte_three", "reply_byte_four", "reply_byte_five", "reply_byte_six",
		"reply_check"};

	bit quiet = 1'b0;
	int fail_count = 0;
	int packets_sent = 0;
	int packets_dropped = 0;
	int replies_checked = 0;
	int store_sweeps = 0;

	crc_checked_sample_buffer_commands_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reflected CRC-8 over seven bytes; byte 0 sits in msg[55:48], each byte LSB first
	function automatic logic [7:0] crc8_message(input logic [55:0] msg);
		logic [7:0] r;
		logic       fb;
		r = 8'h00;
		for (int k = 0; k < 7; k++) begin
			for (int j = 0; j < 8; j++) begin
				fb = r[0] ^ msg[48 - 8 * k + j];
				r  = (r >> 1) ^ (fb ? CRC_POLY : 8'h00);
			end
		end
		return r;
	endfunction

	// Apply one packet to the shadow state; return 1 when it earns a reply
	function automatic bit execute_command(input cmd_pkt_t p, output reply_pkt_t r);
		logic [IDX_W-1:0] idx;
		bit               in_range;
		r = '1;
		if (shadow_check_on && crc8_message(p[71:16]) != p.check_byte) begin
			return 1'b0;
		end
		idx      = {1'b0, p.index_high, p.index_low};
		in_range = idx < STORE_LIMIT;
		case (p.command)
			CMD_READ: begin
				r.reply_status     = in_range ? ST_DONE : ST_INDEX_ERR;
				r.reply_command    = p.command;
				r.reply_byte_two   = p.index_high;
				r.reply_byte_three = p.index_low;
				if (in_range) begin
					r.reply_byte_four = shadow_store[idx[ADDR_W-1:0]];
				end
			end
			CMD_WRITE: begin
				if (in_range) begin
					shadow_store[idx[ADDR_W-1:0]] = p.write_value;
				end
				r.reply_status     = in_range ? ST_DONE : ST_INDEX_ERR;
				r.reply_command    = p.command;
				r.reply_byte_two   = p.index_high;
				r.reply_byte_three = p.index_low;
				r.reply_byte_four  = p.write_value;
			end
			CMD_ADC: begin
				r.reply_status   = ST_DONE;
				r.reply_command  = p.command;
				r.reply_byte_two = p.adc_value;
			end
			CMD_CLEAR: begin
				foreach (shadow_store[n]) shadow_store[n] = 8'h00;
				r.reply_status  = ST_DONE;
				r.reply_command = p.command;
			end
			CMD_FILL: begin
				foreach (shadow_store[n]) shadow_store[n] = p.index_high;
				r.reply_status   = ST_DONE;
				r.reply_command  = p.command;
				r.reply_byte_two = p.index_high;
			end
			CMD_CHECK_ON: begin
				shadow_check_on = 1'b1;
				r.reply_status  = ST_DONE;
				r.reply_command = p.command;
			end
			CMD_CHECK_OFF: begin
				shadow_check_on = 1'b0;
				r.reply_status  = ST_DONE;
				r.reply_command = p.command;
			end
			default: begin
			end
		endcase
		// Reply CRC follows the mode as it stands after the command
		if (shadow_check_on) begin
			shadow_last_check = crc8_message(r[63:8]);
		end
		r.reply_check = shadow_last_check;
		return 1'b1;
	endfunction

	// Reply with filler in bytes five and six and the reset check byte
	function automatic reply_pkt_t reply_of(input logic [7:0] status, input logic [7:0] command,
			input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4);
		return '{status, command, b2, b3, b4, FILLER, FILLER, 8'h00};
	endfunction

	function automatic void add_row(input logic [7:0] command, input logic [7:0] hi,
			input logic [7:0] lo, input logic [7:0] value, input logic [7:0] adc,
			input crc_fix_t fix, input bit typed, input reply_pkt_t reply);
		stim_row_t row;
		row.pkt   = '{command, hi, lo, value, 8'h00, 8'hFF, 8'h00, 8'h5A, adc};
		row.fix   = fix;
		row.typed = typed;
		row.reply = reply;
		directed_rows.push_back(row);
	endfunction

	// Mostly well-formed commands with random content, some broken CRCs
	function automatic cmd_pkt_t random_packet();
		cmd_pkt_t   p;
		int         pick;
		logic [7:0] code;
		p.index_low   = 8'($urandom);
		p.write_value = 8'($urandom);
		p.arg_four    = 8'($urandom);
		p.arg_five    = 8'($urandom);
		p.arg_six     = 8'($urandom);
		p.adc_value   = 8'($urandom);
		case ($urandom_range(9))
			0: p.index_high = 8'($urandom);
			1: begin
				p.index_high = $urandom_range(1) ? 8'h02 : 8'h01;
				p.index_low  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: p.index_high = 8'($urandom_range(1));
		endcase
		pick = $urandom_range(99);
		if (pick < 30) begin
			p.command = CMD_READ;
		end else if (pick < 54) begin
			p.command = CMD_WRITE;
		end else if (pick < 62) begin
			p.command = CMD_ADC;
		end else if (pick < 65) begin
			p.command = CMD_CLEAR;
		end else if (pick < 68) begin
			p.command    = CMD_FILL;
			p.index_high = 8'($urandom);
		end else if (pick < 74) begin
			p.command = CMD_CHECK_ON;
		end else if (pick < 79) begin
			p.command = CMD_CHECK_OFF;
		end else begin
			do code = 8'($urandom_range(255));
			while (code inside {CMD_READ, CMD_WRITE, CMD_ADC, CMD_CLEAR, CMD_FILL,
				CMD_CHECK_ON, CMD_CHECK_OFF});
			p.command = code;
		end
		p.check_byte = crc8_message(p[71:16]);
		if ($urandom_range(9) == 0) begin
			p.check_byte ^= 8'(1 << $urandom_range(7));
		end
		return p;
	endfunction

	// Offer one packet, hold it until taken, then predict its reply
	task automatic send_packet(input cmd_pkt_t p, input bit typed, input reply_pkt_t typed_reply,
			output bit answered);
		reply_pkt_t predicted;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= p;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		packets_sent++;
		answered = execute_command(p, predicted);
		if (answered && (p.command == CMD_CLEAR || p.command == CMD_FILL)) begin
			store_sweeps++;
		end
		if (!answered) begin
			packets_dropped++;
		end else if (typed) begin
			pending_replies.push_back(typed_reply);
		end else begin
			pending_replies.push_back(predicted);
		end
	endtask

	// Compare one reply against the oldest prediction, field by field
	task automatic compare_reply(input reply_pkt_t got);
		reply_pkt_t want;
		logic [7:0] w;
		logic [7:0] g;
		if (pending_replies.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: reply with none expected: %h", $realtime, got);
			end
			return;
		end
		want = pending_replies.pop_front();
		replies_checked++;
		for (int f = 0; f < 8; f++) begin
			w = want[63 - 8 * f -: 8];
			g = got[63 - 8 * f -: 8];
			if (g !== w) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: reply %0d %s expected %h got %h", $realtime,
						replies_checked, reply_field_name[f], w, g);
				end
			end
		end
	endtask

	// Take replies and throttle the reply channel
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				compare_reply(rsp);
			end
			rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Reset, directed table, random traffic, drain and verdict
	initial begin
		bit         answered;
		int         random_replies;
		cmd_pkt_t   p;
		reply_pkt_t none;
		none = '0;
		random_replies = 0;
		foreach (shadow_store[n]) shadow_store[n] = 8'h00;

		// Check off first so the reply check stays at its reset value
		add_row(CMD_CHECK_OFF, 8'h00, 8'h00, 8'h00, 8'h00, CRC_GOOD, 1'b1,
			reply_of(ST_DONE, CMD_CHECK_OFF, FILLER, FILLER, FILLER));
		add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_READ, 8'h00, 8'h00, 8'h00));
		add_row(CMD_WRITE, 8'h01, 8'hFF, 8'hFF, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_WRITE, 8'h01, 8'hFF, 8'hFF));
		add_row(CMD_READ, 8'h01, 8'hFF, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_READ, 8'h01, 8'hFF, 8'hFF));
		add_row(CMD_READ, 8'h02, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_INDEX_ERR, CMD_READ, 8'h02, 8'h00, FILLER));
		add_row(CMD_WRITE, 8'hFF, 8'hFF, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_INDEX_ERR, CMD_WRITE, 8'hFF, 8'hFF, 8'h00));
		add_row(CMD_READ, 8'hFF, 8'hFF, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_INDEX_ERR, CMD_READ, 8'hFF, 8'hFF, FILLER));
		add_row(CMD_ADC, 8'h00, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_ADC, 8'h00, FILLER, FILLER));
		add_row(CMD_ADC, 8'h00, 8'h00, 8'h00, 8'hFF, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_ADC, 8'hFF, FILLER, FILLER));
		add_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(FILLER, FILLER, FILLER, FILLER, FILLER));
		add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CRC_RAW, 1'b1,
			reply_of(FILLER, FILLER, FILLER, FILLER, FILLER));
		add_row(8'd5, 8'h00, 8'h10, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(FILLER, FILLER, FILLER, FILLER, FILLER));
		add_row(8'd12, 8'h00, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(FILLER, FILLER, FILLER, FILLER, FILLER));
		add_row(CMD_FILL, 8'hA5, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_FILL, 8'hA5, FILLER, FILLER));
		add_row(CMD_READ, 8'h01, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_READ, 8'h01, 8'h00, 8'hA5));
		add_row(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_CLEAR, FILLER, FILLER, FILLER));
		add_row(CMD_READ, 8'h01, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b1,
			reply_of(ST_DONE, CMD_READ, 8'h01, 8'h00, 8'h00));
		// Back in check mode: replies carry a computed CRC
		add_row(CMD_CHECK_ON, 8'h00, 8'h00, 8'h00, 8'h00, CRC_RAW, 1'b0, none);
		add_row(CMD_READ, 8'h01, 8'hFF, 8'h00, 8'h00, CRC_GOOD, 1'b0, none);
		add_row(CMD_WRITE, 8'h00, 8'h05, 8'h3C, 8'h00, CRC_BAD, 1'b0, none);
		add_row(CMD_READ, 8'h00, 8'h05, 8'h00, 8'h00, CRC_GOOD, 1'b0, none);
		add_row(CMD_WRITE, 8'h00, 8'h05, 8'h3C, 8'h00, CRC_GOOD, 1'b0, none);
		add_row(CMD_READ, 8'h00, 8'h05, 8'h00, 8'h00, CRC_GOOD, 1'b0, none);
		add_row(8'd6, 8'h00, 8'h00, 8'h00, 8'h00, CRC_GOOD, 1'b0, none);
		add_row(CMD_CHECK_OFF, 8'h00, 8'h00, 8'h00, 8'h00, CRC_GOOD, 1'b0, none);

		// Hold reset, then release it on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			p = directed_rows[i].pkt;
			if (directed_rows[i].fix != CRC_RAW) begin
				p.check_byte = crc8_message(p[71:16]);
			end
			if (directed_rows[i].fix == CRC_BAD) begin
				p.check_byte ^= 8'h01;
			end
			send_packet(p, directed_rows[i].typed, directed_rows[i].reply, answered);
		end

		// Random traffic, with a full-rate stretch in the middle
		while (random_replies < RANDOM_REPLIES) begin
			quiet = random_replies >= 200 && random_replies < 320;
			send_packet(random_packet(), 1'b0, none, answered);
			if (answered) begin
				random_replies++;
			end
		end
		quiet = 1'b0;
		req_valid <= 1'b0;

		// Drain outstanding replies, then watch for strays
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d packets (%0d dropped on a bad CRC), compared %0d replies",
			packets_sent, packets_dropped, replies_checked);
		$display("Store clear/fill sweeps: %0d, failures: %0d", store_sweeps, fail_count);
		if (fail_count == 0) begin
			$display("crc_checked_sample_buffer_commands_top_test: PASS");
		end else begin
			$display("crc_checked_sample_buffer_commands_top_test: FAIL");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("Timeout with %0d replies outstanding", pending_replies.size());
		$display("crc_checked_sample_buffer_commands_top_test: FAIL");
		$finish;
	end

endmodule
